/* design/mmnb_pkg.sv */
// Shared types and codes for the min-max normalize-to-byte block.
`timescale 1ns / 1ps

package mmnb_pkg;

    // Input action codes.
    localparam logic [1:0] ACT_SCAN    = 2'd0;
    localparam logic [1:0] ACT_CONVERT = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    // Full-scale pixel value.
    localparam logic [7:0] PIXEL_FULL = 8'd255;

    // Quotient bits produced by the back-end divider.
    localparam int unsigned QUOT_BITS = 8;

    // One input item.
    typedef struct packed {
        logic [1:0]         action;
        logic signed [15:0] sample;
    } mmnb_in_t;

    // One result item.
    typedef struct packed {
        logic [7:0] pixel;
        logic       degenerate;
    } mmnb_out_t;

    // Control part of a queued conversion job.
    typedef struct packed {
        logic       is_div;
        logic [7:0] pixel;
        logic       degenerate;
    } mmnb_job_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WRITE
    } mmnb_state_t;

endpackage

/* design/mmnb_front.sv */
// Front end: takes input transfers, keeps the extrema and classifies conversions.
`timescale 1ns / 1ps

module mmnb_front #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wen,
    input  logic                   cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  mmnb_pkg::mmnb_in_t     s_data,
    input  logic                   q_full,
    output logic                   q_push,
    output mmnb_pkg::mmnb_job_t    q_job,
    output logic [SAMPLE_BITS-1:0] q_dist,
    output logic [SAMPLE_BITS-1:0] q_range
);
    import mmnb_pkg::*;

    localparam int RW = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
    localparam int CW = (SAMPLE_BITS > FRAC_BITS + 2) ? SAMPLE_BITS : FRAC_BITS + 2;
    localparam logic signed [CW-1:0] ONE = CW'(1) << FRAC_BITS;

    logic signed [SAMPLE_BITS-1:0] max_reg, max_next;
    logic signed [SAMPLE_BITS-1:0] min_reg, min_next;
    logic                          clamp_reg;

    logic [RW-1:0]                 raw;
    logic signed [SAMPLE_BITS-1:0] x;
    logic                          take;
    logic signed [SAMPLE_BITS:0]   dist_full;
    logic                          range_zero;
    logic                          x_ge_max;
    logic signed [CW-1:0]          xc;
    logic [FRAC_BITS:0]            xs;
    logic [FRAC_BITS+8:0]          prod;

    // Only the low SAMPLE_BITS bits of the sample carry the value.
    assign raw  = RW'($unsigned(s_data.sample));
    assign x    = $signed(raw[SAMPLE_BITS-1:0]);
    assign take = s_valid && s_ready;

    assign s_ready = !q_full;

    // Normalize-mode classification against the current extrema.
    assign dist_full  = {x[SAMPLE_BITS-1], x} - {min_reg[SAMPLE_BITS-1], min_reg};
    assign range_zero = (max_reg == min_reg);
    assign x_ge_max   = (x >= max_reg);
    assign q_dist     = dist_full[SAMPLE_BITS-1:0];
    assign q_range    = max_reg - min_reg;

    // Clamp-mode scaling: x * 255 computed as (x << 8) - x.
    assign xc   = CW'(x);
    assign xs   = xc[FRAC_BITS:0];
    assign prod = {xs, 8'b0} - {8'b0, xs};

    // Build the job for a convert transfer.
    always_comb begin
        q_job = '0;
        if (clamp_reg) begin
            if (xc > ONE) begin
                q_job.pixel = PIXEL_FULL;
            end else if (xc < 0) begin
                q_job.pixel = '0;
            end else begin
                q_job.pixel = prod[FRAC_BITS+7:FRAC_BITS];
            end
        end else begin
            priority if (range_zero) begin
                q_job.degenerate = 1'b1;
            end else if (dist_full < 0) begin
                q_job.pixel = '0;
            end else if (x_ge_max) begin
                q_job.pixel = PIXEL_FULL;
            end else begin
                q_job.is_div = 1'b1;
            end
        end
    end

    assign q_push = take && (s_data.action == ACT_CONVERT);

    // Running extrema update for scan and restart transfers.
    always_comb begin
        max_next = max_reg;
        min_next = min_reg;
        if (take) begin
            if (s_data.action == ACT_SCAN) begin
                if (x > max_reg) begin
                    max_next = x;
                end
                if (x < min_reg) begin
                    min_next = x;
                end
            end else if (s_data.action == ACT_RESTART) begin
                max_next = '0;
                min_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg   <= '0;
            min_reg   <= '0;
            clamp_reg <= 1'b0;
        end else begin
            max_reg <= max_next;
            min_reg <= min_next;
            if (cfg_wen) begin
                clamp_reg <= cfg_wdata;
            end
        end
    end

    // The extrema always bracket zero since both start there.
    a_extrema_bracket_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (max_reg >= 0) && (min_reg <= 0))
        else $error("running extrema do not bracket zero");

endmodule

/* design/mmnb_fifo.sv */
// Two-entry job queue between the front end and the divider back end.
`timescale 1ns / 1ps

module mmnb_fifo #(
    parameter int WIDTH = 41
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             not_empty
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign rd_data   = mem_reg[rd_ptr_reg];

    // Storage write.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // The front end must never push into a full queue, and the back end must never pop an empty one.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full) && !(pop && !not_empty))
        else $error("job queue overflow or underflow");

endmodule

/* design/mmnb_back.sv */
// Back end: runs queued jobs through a shift-subtract divider into the output register.
`timescale 1ns / 1ps

module mmnb_back #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    input  mmnb_pkg::mmnb_job_t    q_job,
    input  logic [SAMPLE_BITS-1:0] q_dist,
    input  logic [SAMPLE_BITS-1:0] q_range,
    output logic                   q_pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output mmnb_pkg::mmnb_out_t    m_data
);
    import mmnb_pkg::*;

    localparam int NW = SAMPLE_BITS + QUOT_BITS;
    localparam logic [2:0] LAST_STEP = 3'(QUOT_BITS - 1);

    mmnb_state_t              state_reg, state_next;
    logic [SAMPLE_BITS-1:0]   rem_reg;
    logic [SAMPLE_BITS-1:0]   range_reg;
    logic [QUOT_BITS-1:0]     sh_reg;
    logic [2:0]               cnt_reg;
    logic                     out_valid_reg;
    mmnb_out_t                out_data_reg;

    logic                     out_free;
    logic                     load_div;
    logic                     direct_wr;
    logic                     div_wr;
    logic [NW-1:0]            num;
    logic [SAMPLE_BITS:0]     trial;
    logic [SAMPLE_BITS:0]     trial_diff;
    logic                     trial_ge;

    assign out_free = !out_valid_reg || m_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    // Numerator (x - min) * 255 as a shift and subtract; the quotient stays below 255.
    assign num = {q_dist, {QUOT_BITS{1'b0}}} - {{QUOT_BITS{1'b0}}, q_dist};

    // One restoring division step.
    assign trial      = {rem_reg, sh_reg[QUOT_BITS-1]};
    assign trial_diff = trial - {1'b0, range_reg};
    assign trial_ge   = (trial >= {1'b0, range_reg});

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && q_job.is_div) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (cnt_reg == LAST_STEP) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        load_div  = 1'b0;
        direct_wr = 1'b0;
        div_wr    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                load_div  = q_valid && q_job.is_div;
                direct_wr = q_valid && !q_job.is_div && out_free;
            end
            ST_DIV: begin
            end
            ST_WRITE: begin
                div_wr = out_free;
            end
            default: begin
            end
        endcase
    end

    assign q_pop = load_div || direct_wr;

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (direct_wr || div_wr) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Divider datapath and output payload.
    always_ff @(posedge aclk) begin
        if (load_div) begin
            rem_reg   <= num[NW-1:QUOT_BITS];
            sh_reg    <= num[QUOT_BITS-1:0];
            range_reg <= q_range;
            cnt_reg   <= 3'd0;
        end else if (state_reg == ST_DIV) begin
            rem_reg <= trial_ge ? trial_diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
            sh_reg  <= {sh_reg[QUOT_BITS-2:0], trial_ge};
            cnt_reg <= cnt_reg + 3'd1;
        end
        if (direct_wr) begin
            out_data_reg.pixel      <= q_job.pixel;
            out_data_reg.degenerate <= q_job.degenerate;
        end else if (div_wr) begin
            out_data_reg.pixel      <= sh_reg;
            out_data_reg.degenerate <= 1'b0;
        end
    end

    // The partial remainder stays below the divisor during division.
    a_rem_below_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < range_reg))
        else $error("divider remainder reached the divisor");

    // A degenerate result always carries pixel zero.
    a_degenerate_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.degenerate) |-> (m_data.pixel == '0))
        else $error("degenerate result with nonzero pixel");

    // The output register is loaded only when free.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (direct_wr || div_wr) |-> out_free)
        else $error("result overwritten before transfer");

endmodule

/* design/minmax_normalize_to_byte_core.sv */
// Top level of the min-max normalize-to-byte block.
//
// Channel    Direction  Handshake          Payload
// s_         in         s_valid/s_ready    mmnb_in_t  (action, sample)
// m_         out        m_valid/m_ready    mmnb_out_t (pixel, degenerate)
// cfg_       in         cfg_wen            cfg_wdata  (clamp_mode)
//
// Scan, restart and unused-action transfers never produce a result. Clamp-mode and special-case
// conversions are resolved in the front end and leave at one per cycle unless the back end is busy
// or the output stalls. A normalize conversion that needs a quotient takes, in the back end,
// one load, eight shift-subtract divider steps, one write to the output register.
// A two-entry job queue lets the front end keep scanning while the divider works.
// Reset is synchronous and active low; it clears the extrema, clamp_mode and all control.
`timescale 1ns / 1ps

module minmax_normalize_to_byte_core #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wen,
    input  logic                cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  mmnb_pkg::mmnb_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mmnb_pkg::mmnb_out_t m_data
);
    import mmnb_pkg::*;

    localparam int JW = $bits(mmnb_job_t);
    localparam int QW = JW + 2 * SAMPLE_BITS;

    logic                   q_full;
    logic                   q_not_empty;
    logic                   q_push;
    logic                   q_pop;
    mmnb_job_t              push_job;
    logic [SAMPLE_BITS-1:0] push_dist;
    logic [SAMPLE_BITS-1:0] push_range;
    logic [QW-1:0]          q_wr_data;
    logic [QW-1:0]          q_rd_data;
    mmnb_job_t              pop_job;
    logic [SAMPLE_BITS-1:0] pop_dist;
    logic [SAMPLE_BITS-1:0] pop_range;

    // Front end.
    mmnb_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (push_job),
        .q_dist    (push_dist),
        .q_range   (push_range)
    );

    // Job queue.
    assign q_wr_data = {push_job, push_dist, push_range};
    assign pop_job   = q_rd_data[QW-1:2*SAMPLE_BITS];
    assign pop_dist  = q_rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign pop_range = q_rd_data[SAMPLE_BITS-1:0];

    mmnb_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .wr_data   (q_wr_data),
        .pop       (q_pop),
        .rd_data   (q_rd_data),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    // Back end.
    mmnb_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_not_empty),
        .q_job   (pop_job),
        .q_dist  (pop_dist),
        .q_range (pop_range),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* dv/tb_minmax_normalize_to_byte_core.sv */
// Self-checking testbench for the min-max normalize-to-byte core.
`timescale 1ns / 1ps

module tb_minmax_normalize_to_byte_core;

    import mmnb_pkg::*;

    // Longest run of cycles without any transfer before the run is declared hung.
    localparam int unsigned HANG_LIMIT = 4000;
    // Cycles allowed for the back end to finish after the last expected pixel.
    localparam int unsigned SETTLE_CYCLES = 30;
    // Number of received pixels after which the receiver holds off once.
    localparam int unsigned HOLD_AT_RESULT = 120;
    localparam int unsigned HOLD_CYCLES = 400;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      cfg_wen = 1'b0;
    logic      cfg_wdata = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    mmnb_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    mmnb_out_t m_data;

    // Items waiting to be offered and pixels waiting to come out.
    mmnb_in_t  sample_feed [$];
    mmnb_out_t pixel_due [$];

    // Predictor copy of the block's extrema and mode.
    logic signed [15:0] ext_max = '0;
    logic signed [15:0] ext_min = '0;
    logic               clamp_cfg = 1'b0;

    int unsigned items_queued = 0;
    int unsigned items_taken = 0;
    int unsigned pixels_seen = 0;
    int unsigned error_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    bit          no_idle = 1'b0;

    minmax_normalize_to_byte_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Clock generation.
    initial begin
        forever #4 aclk = ~aclk;
    end

    // Update the extrema for one accepted item and work out its pixel, if any.
    function automatic bit predict_pixel(input mmnb_in_t item, output mmnb_out_t pix);
        logic signed [15:0] x;
        int                 span;
        int                 num;
        int                 quot;
        x   = item.sample;
        pix = '0;
        case (item.action)
            ACT_SCAN: begin
                if (x > ext_max) ext_max = x;
                if (x < ext_min) ext_min = x;
                return 1'b0;
            end
            ACT_RESTART: begin
                ext_max = '0;
                ext_min = '0;
                return 1'b0;
            end
            ACT_CONVERT: begin
                if (clamp_cfg) begin
                    // Clamp to the unit range, then scale by full scale.
                    if (x > 16'sd256) pix.pixel = PIXEL_FULL;
                    else if (x < 16'sd0) pix.pixel = 8'd0;
                    else pix.pixel = 8'((int'(x) * int'(PIXEL_FULL)) >>> 8);
                    return 1'b1;
                end
                span = int'(ext_max) - int'(ext_min);
                if (span <= 0) begin
                    // Zero range gives pixel 0 with the degenerate flag.
                    pix.degenerate = 1'b1;
                    return 1'b1;
                end
                num = (int'(x) - int'(ext_min)) * int'(PIXEL_FULL);
                quot = (num < 0) ? 0 : num / span;
                pix.pixel = (quot > int'(PIXEL_FULL)) ? PIXEL_FULL : 8'(quot);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Input driver: offers queued items and predicts each transfer.
    always @(posedge aclk) begin
        mmnb_out_t pix;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (predict_pixel(s_data, pix)) pixel_due.push_back(pix);
                items_taken++;
            end
            if (!s_valid || s_ready) begin
                if (sample_feed.size() > 0 && (no_idle || $urandom_range(99) >= 13)) begin
                    s_data  <= sample_feed.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: checks each pixel transfer and drives the ready side.
    always @(posedge aclk) begin
        mmnb_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pixel_due.size() == 0) begin
                    $display("%0t: unexpected pixel transfer, actual pixel=%0d degenerate=%0b",
                             $time, m_data.pixel, m_data.degenerate);
                    error_count++;
                end else begin
                    want = pixel_due.pop_front();
                    if (m_data.pixel !== want.pixel) begin
                        $display("%0t: pixel mismatch, expected %0d, actual %0d",
                                 $time, want.pixel, m_data.pixel);
                        error_count++;
                    end
                    if (m_data.degenerate !== want.degenerate) begin
                        $display("%0t: degenerate mismatch, expected %0b, actual %0b",
                                 $time, want.degenerate, m_data.degenerate);
                        error_count++;
                    end
                end
                pixels_seen++;
            end
            // One long hold-off so the job queue fills and the input stalls.
            if (!hold_done && pixels_seen >= HOLD_AT_RESULT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= no_idle || ($urandom_range(99) >= 13);
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= HANG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, HANG_LIMIT);
                $display("[minmax_normalize_to_byte_core] ERROR");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic push_item(input logic [1:0] act, input logic [15:0] smp);
        mmnb_in_t item;
        item.action = act;
        item.sample = smp;
        sample_feed.push_back(item);
        items_queued++;
    endtask

    // Wait until every item is taken and every pixel has arrived, then let the core settle.
    task automatic drain_all();
        wait (items_taken == items_queued);
        wait (pixel_due.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_clamp(input logic mode);
        drain_all();
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= mode;
        clamp_cfg = mode;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
    endtask

    // Random frames: usually a restart, then a scan pass and a convert pass, with some noise mixed in.
    task automatic queue_frames(input int budget);
        int                 made;
        int                 len;
        int                 span;
        int                 pick;
        logic [15:0]        base;
        logic [15:0]        frame [$];
        made = 0;
        while (made < budget) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                push_item(2'($urandom), 16'($urandom));
                made++;
            end else begin
                frame.delete();
                len = $urandom_range(1, 10);
                case ($urandom_range(3))
                    0: span = 65535;
                    1: span = $urandom_range(15);
                    2: span = 0;
                    default: span = $urandom_range(2000);
                endcase
                base = (span == 0 && $urandom_range(1)) ? 16'd0 : 16'($urandom);
                for (int i = 0; i < len; i++) begin
                    frame.push_back(16'(base + $urandom_range(span)));
                end
                // Now and then skip the restart so extrema carry over.
                if ($urandom_range(99) >= 10) begin
                    push_item(ACT_RESTART, 16'($urandom));
                    made++;
                end
                foreach (frame[i]) push_item(ACT_SCAN, frame[i]);
                foreach (frame[i]) begin
                    if ($urandom_range(99) < 15) push_item(ACT_CONVERT, 16'($urandom));
                    else push_item(ACT_CONVERT, frame[i]);
                end
                made += 2 * len;
            end
        end
    endtask

    // Main sequence: reset, directed cases, then random phases in both modes.
    initial begin
        int pick;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Normalize mode from reset: zero range, an ignored code, full-scale extrema.
        push_item(ACT_CONVERT, 16'h0000);
        push_item(2'd3, 16'h7FFF);
        push_item(ACT_CONVERT, 16'h0010);
        push_item(ACT_SCAN, 16'h7FFF);
        push_item(ACT_SCAN, 16'h8000);
        push_item(ACT_CONVERT, 16'h7FFF);
        push_item(ACT_CONVERT, 16'h8000);
        push_item(ACT_CONVERT, 16'h0000);
        push_item(ACT_RESTART, 16'h1234);
        push_item(ACT_CONVERT, 16'h0005);
        push_item(ACT_SCAN, 16'h0100);
        push_item(ACT_CONVERT, 16'h012C);
        push_item(ACT_CONVERT, 16'hFFFF);
        push_item(ACT_CONVERT, 16'h0080);
        push_item(2'd3, 16'h03E8);
        push_item(ACT_CONVERT, 16'h0100);
        write_clamp(1'b1);

        // Clamp mode: exactly one, just above and below it, zero, negative, extremes.
        push_item(ACT_CONVERT, 16'h0100);
        push_item(ACT_CONVERT, 16'h0101);
        push_item(ACT_CONVERT, 16'h00FF);
        push_item(ACT_CONVERT, 16'h0000);
        push_item(ACT_CONVERT, 16'hFFFF);
        push_item(ACT_CONVERT, 16'h7FFF);
        push_item(ACT_CONVERT, 16'h8000);
        push_item(ACT_SCAN, 16'h0040);
        push_item(ACT_CONVERT, 16'h0001);
        write_clamp(1'b0);

        queue_frames(400);
        write_clamp(1'b1);

        // Clamp mode random items; half of the conversions are drawn near the unit range.
        for (int n = 0; n < 250; n++) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                if ($urandom_range(1)) push_item(ACT_CONVERT, 16'($urandom_range(800) - 200));
                else push_item(ACT_CONVERT, 16'($urandom));
            end else if (pick < 85) begin
                push_item(ACT_SCAN, 16'($urandom));
            end else if (pick < 95) begin
                push_item(ACT_RESTART, 16'($urandom));
            end else begin
                push_item(2'd3, 16'($urandom));
            end
        end
        write_clamp(1'b0);

        // Last phase runs with both sides always willing.
        no_idle = 1'b1;
        queue_frames(250);
        drain_all();

        if (error_count == 0) begin
            $display("[minmax_normalize_to_byte_core] OK");
        end else begin
            $display("[minmax_normalize_to_byte_core] ERROR");
        end
        $finish;
    end

endmodule
